[rtl/core/euc_to_jis_or_sjis_converter_assert.svh]
// Assertion macros for the EUC-JP converter.
// Each macro expects clk and rst to be visible at the point of use.
`ifndef EUC_TO_JIS_OR_SJIS_CONVERTER_ASSERT_SVH
`define EUC_TO_JIS_OR_SJIS_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define EJC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define EJC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define EJC_ASSERT_NOW(lbl, ante, cons, msg)
`define EJC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/core/ejc_pkg.sv]
package ejc_pkg;

  // Output code register values (3 behaves as pass-through)
  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_JIS  = 2'd1;
  localparam logic [1:0] MODE_SJIS = 2'd2;

  // Longest burst one input byte can cause: ESC $ B, byte, ESC ( B
  localparam int MAX_RESULTS = 7;
  localparam int BURST_IDX_W = $clog2(MAX_RESULTS);

  // Escape sequence bytes
  localparam logic [7:0] ESC_BYTE      = 8'h1B;
  localparam logic [7:0] JIS_KANJI_MID = 8'h24;
  localparam logic [7:0] JIS_ASCII_MID = 8'h28;
  localparam logic [7:0] ESC_FINAL     = 8'h42;

  // Shift-JIS arithmetic constants
  localparam logic [6:0] SJIS_ROW_SPLIT   = 7'h5E;
  localparam logic [7:0] SJIS_LEAD_LOW    = 8'h71;
  localparam logic [7:0] SJIS_LEAD_HIGH   = 8'hB1;
  localparam logic [6:0] SJIS_TRAIL_SPLIT = 7'h60;
  localparam logic [7:0] SJIS_ODD_LOW     = 8'h1F;
  localparam logic [7:0] SJIS_ODD_HIGH    = 8'h20;
  localparam logic [7:0] SJIS_EVEN        = 8'h7E;

  typedef logic [7:0] byte_t;

  // One burst of output bytes caused by a single input byte
  typedef struct packed {
    byte_t [MAX_RESULTS-1:0] bytes;
    logic [BURST_IDX_W-1:0]  last_idx;
    logic                    string_end;
  } burst_t;

endpackage

[rtl/core/ejc_if.sv]
// Input byte channel
interface ejc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// Output byte channel
interface ejc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       string_end;
  logic       run_last;

  modport source (output valid, output out_byte, output string_end, output run_last,
                  input ready);
  modport sink   (input valid, input out_byte, input string_end, input run_last,
                  output ready);
endinterface

[rtl/core/euc_to_jis_or_sjis_converter.sv]
// Channel  Dir  Payload                          Handshake
// din      in   in_byte[7:0], in_last            valid / ready
// dout     out  out_byte[7:0], string_end,       valid / ready
//               run_last
// cfg      in   output_code[1:0]                 output_code_we
//
// One input byte per cycle while dout is ready, when each byte yields one output
// byte; a byte that yields a burst of k bytes (JIS escapes, Shift-JIS pair) holds
// the single burst register until all k have gone, stepped by its byte index.
// A held Shift-JIS lead byte is accepted and yields nothing.
// Reset (rst, synchronous) empties the burst register and clears mode state.
// A stall on dout holds the burst; din.ready drops until its last byte goes.
module euc_to_jis_or_sjis_converter
  import ejc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       output_code_we,
  input  logic [1:0] output_code,
  ejc_in_if.sink     din,
  ejc_out_if.source  dout
);

`include "euc_to_jis_or_sjis_converter_assert.svh"

  logic [1:0] code;
  logic       fire;
  logic       has_result;
  logic       can_load;
  burst_t     burst;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      code <= MODE_PASS;
    end else if (output_code_we) begin
      code <= output_code;
    end
  end

  assign din.ready = can_load;
  assign fire      = din.valid && din.ready;

  ejc_encode u_encode (
    .clk            (clk),
    .rst            (rst),
    .output_code    (code),
    .output_code_we (output_code_we),
    .fire           (fire),
    .in_byte        (din.in_byte),
    .in_last        (din.in_last),
    .has_result     (has_result),
    .burst          (burst)
  );

  ejc_burst u_burst (
    .clk      (clk),
    .rst      (rst),
    .load     (fire && has_result),
    .burst_in (burst),
    .can_load (can_load),
    .dout     (dout)
  );

  // Checks
  `EJC_ASSERT_NOW(a_end_on_run_last, dout.valid && dout.string_end, dout.run_last, "end off run")
  `EJC_ASSERT_NOW(a_ready, din.ready, !dout.valid || (dout.run_last && dout.ready), "ready busy")
  `EJC_ASSERT_NEXT(a_kept, dout.valid && !(dout.run_last && dout.ready), dout.valid, "dropped")

endmodule

[rtl/core/ejc_encode.sv]
// Converts one accepted byte into a burst and keeps the conversion state.
module ejc_encode
  import ejc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] output_code,
  input  logic       output_code_we,
  input  logic       fire,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       has_result,
  output burst_t     burst
);

  logic       kanji_mode;
  logic       lead_pending;
  logic [6:0] lead_row;
  logic       kanji_mode_next;
  logic       lead_pending_next;
  logic [6:0] lead_row_next;

  logic                   hi;
  logic [6:0]             low7;
  logic [7:0]             row_m1;
  logic [7:0]             sjis_s1;
  logic [7:0]             trail_add;
  logic [7:0]             sjis_s2;
  byte_t [MAX_RESULTS-1:0] bytes;
  logic [BURST_IDX_W-1:0] n;

  assign hi   = in_byte[7];
  assign low7 = in_byte[6:0];

  // Shift-JIS pair arithmetic, all mod 256
  assign row_m1    = {1'b0, lead_row} - 8'd1;
  assign sjis_s1   = {1'b0, row_m1[7:1]} +
                     ((lead_row <= SJIS_ROW_SPLIT) ? SJIS_LEAD_LOW : SJIS_LEAD_HIGH);
  assign trail_add = lead_row[0] ? ((low7 < SJIS_TRAIL_SPLIT) ? SJIS_ODD_LOW : SJIS_ODD_HIGH)
                                 : SJIS_EVEN;
  assign sjis_s2   = {1'b0, low7} + trail_add;

  // Burst assembly and next state
  always_comb begin
    bytes             = '0;
    n                 = '0;
    has_result        = 1'b1;
    kanji_mode_next   = kanji_mode;
    lead_pending_next = lead_pending;
    lead_row_next     = lead_row;
    case (output_code)
      MODE_JIS: begin
        if (kanji_mode != hi) begin
          bytes[0] = ESC_BYTE;
          bytes[1] = hi ? JIS_KANJI_MID : JIS_ASCII_MID;
          bytes[2] = ESC_FINAL;
          n        = BURST_IDX_W'(3);
        end
        bytes[n] = {1'b0, low7};
        // kanji run closed at string end
        if (in_last && hi) begin
          bytes[n + BURST_IDX_W'(1)] = ESC_BYTE;
          bytes[n + BURST_IDX_W'(2)] = JIS_ASCII_MID;
          bytes[n + BURST_IDX_W'(3)] = ESC_FINAL;
          n = n + BURST_IDX_W'(3);
        end
        kanji_mode_next = hi;
      end
      MODE_SJIS: begin
        if (lead_pending) begin
          bytes[0]          = sjis_s1;
          bytes[1]          = sjis_s2;
          n                 = BURST_IDX_W'(1);
          lead_pending_next = 1'b0;
        end else if (hi) begin
          // hold the lead; a lone lead at string end is dropped
          has_result        = 1'b0;
          lead_row_next     = low7;
          lead_pending_next = 1'b1;
        end else begin
          bytes[0] = in_byte;
        end
      end
      default: begin
        bytes[0] = in_byte;
      end
    endcase
    if (in_last) begin
      kanji_mode_next   = 1'b0;
      lead_pending_next = 1'b0;
    end
  end

  assign burst.bytes      = bytes;
  assign burst.last_idx   = n;
  assign burst.string_end = in_last;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kanji_mode   <= 1'b0;
      lead_pending <= 1'b0;
      lead_row     <= '0;
    end else if (output_code_we) begin
      kanji_mode   <= 1'b0;
      lead_pending <= 1'b0;
    end else if (fire) begin
      kanji_mode   <= kanji_mode_next;
      lead_pending <= lead_pending_next;
      lead_row     <= lead_row_next;
    end
  end

endmodule

[rtl/core/ejc_burst.sv]
// Result register: holds one burst and sends it out a byte per transaction.
module ejc_burst
  import ejc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  burst_t     burst_in,
  output logic       can_load,
  ejc_out_if.source  dout
);

  logic                   bvalid;
  burst_t                 burst;
  logic [BURST_IDX_W-1:0] idx;
  logic                   at_last;
  logic                   take;
  logic                   done_now;

  assign at_last  = (idx == burst.last_idx);
  assign take     = bvalid && dout.ready;
  assign done_now = take && at_last;
  assign can_load = !bvalid || done_now;

  assign dout.valid      = bvalid;
  assign dout.out_byte   = burst.bytes[idx];
  assign dout.run_last   = at_last;
  assign dout.string_end = at_last && burst.string_end;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= 1'b0;
      idx    <= '0;
    end else if (load) begin
      bvalid <= 1'b1;
      idx    <= '0;
    end else if (done_now) begin
      bvalid <= 1'b0;
    end else if (take) begin
      idx <= idx + BURST_IDX_W'(1);
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      burst <= burst_in;
    end
  end

endmodule
